[sv/rwnh_pkg.sv]
// Shared types, widths and constants for the ray/wall nearest-hit block.
// No dependencies; every other file imports this package.
package rwnh_pkg;

    localparam int WALL_SLOTS  = 16;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int ANGLE_BITS  = 16;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int DIR_W       = 18;
    localparam int ACC_W       = 52;
    localparam int CORD_W      = 34;
    localparam int CORD_STEPS  = 16;
    localparam int DIST_W      = 24;
    localparam int FRAC_BITS   = 16;
    localparam int LIMIT_W     = 16;
    localparam int DIV_STEPS   = DIST_W;
    localparam int DIV_CNT_W   = 5;
    localparam int STEP_W      = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);
    localparam logic [31:0] QUAD_HALF = 32'h2000_0000;
    localparam logic [DIST_W-1:0] DIST_MISS = '1;
    localparam logic [DIST_W-1:0] MIN_RANGE_RST = DIST_W'(6554);
    localparam logic [COUNT_W-1:0] WALLS_RST = COUNT_W'(3);
    localparam logic [LIMIT_W-1:0] PAR_LIMIT_RST = LIMIT_W'(1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [1:0] {
        REG_MIN_RANGE = 2'd0,
        REG_WALLS     = 2'd1,
        REG_PAR_LIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                      is_cast;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic [ANGLE_BITS-1:0]     angle;
    } cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0]  min_range;
        logic [COUNT_W-1:0] walls_in_use;
        logic [LIMIT_W-1:0] parallel_limit;
    } cfg_t;

    // arctan(2^-i) in Q30 turns of a quarter circle at 2^30
    function automatic logic signed [CORD_W-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            4'd0:    v = 32'h2000_0000;
            4'd1:    v = 32'h12E4_051E;
            4'd2:    v = 32'h09FB_385B;
            4'd3:    v = 32'h0511_11D4;
            4'd4:    v = 32'h028B_0D43;
            4'd5:    v = 32'h0145_D7E1;
            4'd6:    v = 32'h00A2_F61E;
            4'd7:    v = 32'h0051_7C55;
            4'd8:    v = 32'h0028_BE53;
            4'd9:    v = 32'h0014_5F2F;
            4'd10:   v = 32'h000A_2F98;
            4'd11:   v = 32'h0005_17CC;
            4'd12:   v = 32'h0002_8BE6;
            4'd13:   v = 32'h0001_45F3;
            4'd14:   v = 32'h0000_A2FA;
            4'd15:   v = 32'h0000_517D;
            default: v = 32'h0;
        endcase
        return CORD_W'(v);
    endfunction

endpackage

[sv/rwnh_if.sv]
// Request and result channel interfaces (valid/ready with payload).
// Depends on rwnh_pkg.
interface rwnh_in_if import rwnh_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [SLOT_W-1:0]         wall_slot;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [ANGLE_BITS-1:0]     ray_angle;

    modport source (output valid, opcode, wall_slot, start_x, start_y, end_x, end_y,
                    origin_x, origin_y, ray_angle, input ready);
    modport sink (input valid, opcode, wall_slot, start_x, start_y, end_x, end_y,
                  origin_x, origin_y, ray_angle, output ready);
endinterface

interface rwnh_out_if import rwnh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              hit;

    modport source (output valid, distance, hit, input ready);
    modport sink (input valid, distance, hit, output ready);
endinterface

[sv/rwnh_front.sv]
// Front end: accepts requests, classifies them into wall writes and casts,
// and holds them in a two-entry queue for the back end. Depends on rwnh_pkg, rwnh_if.
module rwnh_front import rwnh_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    rwnh_in_if.sink  cmd,
    output cmd_t     head,
    output logic     head_valid,
    input  logic     head_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    cmd_t       entry;

    assign cmd.ready  = (count_reg != 2'd2);
    assign push       = cmd.valid && cmd.ready;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        entry.is_cast = (cmd.opcode == OP_CAST);
        entry.slot    = cmd.wall_slot;
        entry.p0_x    = entry.is_cast ? cmd.origin_x : cmd.start_x;
        entry.p0_y    = entry.is_cast ? cmd.origin_y : cmd.start_y;
        entry.p1_x    = cmd.end_x;
        entry.p1_y    = cmd.end_y;
        entry.angle   = cmd.ray_angle;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

[sv/rwnh_back.sv]
// Back end: wall table, direction CORDIC, per-wall intersection sequencer,
// shift-subtract divider and result register. Depends on rwnh_pkg, rwnh_if.
module rwnh_back import rwnh_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       head_pop,
    input  cfg_t       cfg,
    rwnh_out_if.source res,
    output logic       load_done
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CORDIC = 10'b00_0000_0010,
        ST_ROUND  = 10'b00_0000_0100,
        ST_LOAD   = 10'b00_0000_1000,
        ST_MUL    = 10'b00_0001_0000,
        ST_CHECK  = 10'b00_0010_0000,
        ST_RANGE  = 10'b00_0100_0000,
        ST_DIV    = 10'b00_1000_0000,
        ST_UPDATE = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] tsx [WALL_SLOTS];
    logic signed [COORD_W-1:0] tsy [WALL_SLOTS];
    logic signed [COORD_W-1:0] tex [WALL_SLOTS];
    logic signed [COORD_W-1:0] tey [WALL_SLOTS];

    logic signed [COORD_W-1:0] org_x_reg, org_y_reg;
    logic signed [CORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [1:0]                quad_reg;
    logic signed [DIR_W-1:0]   dx_reg, dy_reg;
    logic [COUNT_W-1:0]        wall_reg, n_reg;
    logic signed [DIFF_W-1:0]  ex_reg, ey_reg, wx_reg, wy_reg;
    logic [2:0]                sub_reg;
    logic signed [ACC_W-1:0]   prod_reg, den_reg, tn_reg, un_reg;
    logic [ACC_W-1:0]          au_reg, ad_reg, rem_reg;
    logic [DIST_W-1:0]         num_low_reg, quo_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [DIST_W-1:0]         d_reg, best_reg;
    logic                      hit_reg;
    logic                      out_valid_reg;
    logic [DIST_W-1:0]         out_dist_reg;
    logic                      out_hit_reg;

    logic [31:0]               phase;
    logic [1:0]                quad;
    logic [31:0]               rr;
    logic signed [CORD_W-1:0]  xs, ys, x_rnd, y_rnd;
    logic signed [DIR_W-1:0]   xr, yr;
    logic [SLOT_W-1:0]         idx;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [2*DIFF_W-1:0] mul_p;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]          den_abs, un_abs, lim;
    logic                      reject;
    logic [COUNT_W-1:0]        wall_inc;
    logic                      last_wall;
    logic [ACC_W:0]            rem2;
    logic                      qbit;
    logic                      out_load;

    assign head_pop  = (state_reg == ST_IDLE) && head_valid;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);
    assign load_done = out_load;
    assign res.valid    = out_valid_reg;
    assign res.distance = out_dist_reg;
    assign res.hit      = out_hit_reg;

    // Quadrant reduction of the heading
    always_comb
    begin
        phase = 32'(head.angle) << (32 - ANGLE_BITS);
        quad  = 2'((phase + QUAD_HALF) >> 30);
        rr    = phase - {quad, 30'b0};
    end

    always_comb
    begin
        xs    = x_reg >>> step_reg;
        ys    = y_reg >>> step_reg;
        x_rnd = (x_reg + CORD_W'(8192)) >>> 14;
        y_rnd = (y_reg + CORD_W'(8192)) >>> 14;
        xr    = x_rnd[DIR_W-1:0];
        yr    = y_rnd[DIR_W-1:0];
    end

    assign idx       = wall_reg[SLOT_W-1:0];
    assign wall_inc  = wall_reg + COUNT_W'(1);
    assign last_wall = (wall_inc == n_reg);

    always_comb
    begin
        case (sub_reg)
            3'd0:    begin mul_a = ex_reg; mul_b = DIFF_W'(dy_reg); end
            3'd1:    begin mul_a = ey_reg; mul_b = DIFF_W'(dx_reg); end
            3'd2:    begin mul_a = wx_reg; mul_b = DIFF_W'(dy_reg); end
            3'd3:    begin mul_a = wy_reg; mul_b = DIFF_W'(dx_reg); end
            3'd4:    begin mul_a = wx_reg; mul_b = ey_reg; end
            3'd5:    begin mul_a = wy_reg; mul_b = ex_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p    = mul_a * mul_b;
        prod_ext = ACC_W'(mul_p);
    end

    // Parallel, parameter range and sign tests for the current wall
    always_comb
    begin
        den_abs = den_reg[ACC_W-1] ? ACC_W'(-den_reg) : ACC_W'(den_reg);
        un_abs  = un_reg[ACC_W-1] ? ACC_W'(-un_reg) : ACC_W'(un_reg);
        lim     = ACC_W'({cfg.parallel_limit, FRAC_BITS'(0)});
        reject  = (den_reg == '0) || (den_abs < lim);
        if (!den_reg[ACC_W-1])
        begin
            if (tn_reg < 0 || tn_reg > den_reg)
                reject = 1'b1;
        end
        else
        begin
            if (tn_reg > 0 || tn_reg < den_reg)
                reject = 1'b1;
        end
        if (un_reg == '0 || (un_reg[ACC_W-1] != den_reg[ACC_W-1]))
            reject = 1'b1;
    end

    always_comb
    begin
        rem2 = {rem_reg, num_low_reg[DIST_W-1]};
        qbit = (rem2 >= {1'b0, ad_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && head.is_cast)
                    state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (step_reg == STEP_W'(CORD_STEPS - 1))
                    state_next = ST_ROUND;
            end
            ST_ROUND:  state_next = (n_reg == '0) ? ST_DONE : ST_LOAD;
            ST_LOAD:   state_next = ST_MUL;
            ST_MUL:
            begin
                if (sub_reg == 3'd6)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!reject)
                    state_next = ST_RANGE;
                else
                    state_next = last_wall ? ST_DONE : ST_LOAD;
            end
            ST_RANGE:
            begin
                if (au_reg >= (ad_reg << 8))
                    state_next = ST_UPDATE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = last_wall ? ST_DONE : ST_LOAD;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && !head.is_cast)
                begin
                    tsx[head.slot] <= head.p0_x;
                    tsy[head.slot] <= head.p0_y;
                    tex[head.slot] <= head.p1_x;
                    tey[head.slot] <= head.p1_y;
                end
                if (head_valid && head.is_cast)
                begin
                    org_x_reg <= head.p0_x;
                    org_y_reg <= head.p0_y;
                    quad_reg  <= quad;
                    z_reg     <= CORD_W'(signed'(rr));
                    x_reg     <= CORDIC_GAIN;
                    y_reg     <= '0;
                    step_reg  <= '0;
                    n_reg     <= (cfg.walls_in_use > COUNT_W'(WALL_SLOTS)) ?
                                 COUNT_W'(WALL_SLOTS) : cfg.walls_in_use;
                    best_reg  <= DIST_MISS;
                    hit_reg   <= 1'b0;
                end
            end
            ST_CORDIC:
            begin
                if (!z_reg[CORD_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val(step_reg);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val(step_reg);
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_ROUND:
            begin
                case (quad_reg)
                    2'd0:    begin dx_reg <= xr;  dy_reg <= yr;  end
                    2'd1:    begin dx_reg <= -yr; dy_reg <= xr;  end
                    2'd2:    begin dx_reg <= -xr; dy_reg <= -yr; end
                    default: begin dx_reg <= yr;  dy_reg <= -xr; end
                endcase
                wall_reg <= '0;
            end
            ST_LOAD:
            begin
                ex_reg  <= DIFF_W'(tex[idx]) - DIFF_W'(tsx[idx]);
                ey_reg  <= DIFF_W'(tey[idx]) - DIFF_W'(tsy[idx]);
                wx_reg  <= DIFF_W'(org_x_reg) - DIFF_W'(tsx[idx]);
                wy_reg  <= DIFF_W'(org_y_reg) - DIFF_W'(tsy[idx]);
                sub_reg <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= prod_ext;
                // accumulate the product registered one step earlier
                case (sub_reg)
                    3'd1:    den_reg <= prod_reg;
                    3'd2:    den_reg <= den_reg - prod_reg;
                    3'd3:    tn_reg  <= prod_reg;
                    3'd4:    tn_reg  <= tn_reg - prod_reg;
                    3'd5:    un_reg  <= prod_reg;
                    3'd6:    un_reg  <= un_reg - prod_reg;
                    default: ;
                endcase
                sub_reg <= sub_reg + 3'd1;
            end
            ST_CHECK:
            begin
                au_reg <= un_abs;
                ad_reg <= den_abs;
                if (reject)
                    wall_reg <= wall_inc;
            end
            ST_RANGE:
            begin
                d_reg       <= DIST_MISS;
                rem_reg     <= au_reg >> 8;
                num_low_reg <= {au_reg[7:0], FRAC_BITS'(0)};
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg     <= qbit ? ACC_W'(rem2 - {1'b0, ad_reg}) : ACC_W'(rem2);
                num_low_reg <= num_low_reg << 1;
                quo_reg     <= {quo_reg[DIST_W-2:0], qbit};
                d_reg       <= {quo_reg[DIST_W-2:0], qbit};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_UPDATE:
            begin
                if (d_reg > cfg.min_range && (!hit_reg || d_reg < best_reg))
                begin
                    best_reg <= d_reg;
                    hit_reg  <= 1'b1;
                end
                wall_reg <= wall_inc;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_dist_reg <= hit_reg ? best_reg : DIST_MISS;
                    out_hit_reg  <= hit_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

[sv/ray_wall_nearest_hit.sv]
// Nearest wall hit along a ray: top level with APB register file.
// Depends on rwnh_pkg, rwnh_if, rwnh_front, rwnh_back.
//
// Usage: requests enter on cmd (valid/ready). Opcode write loads a wall
// segment into one of 16 slots and gives no result; opcode cast gives one
// result on res (distance, hit) for the walls 0..walls_in_use-1, at most 16.
// A cast runs the 16-step direction CORDIC and rounding, then per wall
// the six shared 25x25 multiplies and the tests, plus the 24-step
// shift-subtract division when the wall passes them and needs it.
// The back end works one request at a time; the front end queues
// two more requests meanwhile.
// Registers (APB, byte address 4*i): min_range, walls_in_use, parallel_limit.
// Write them only while no request is in flight.
// Reset clears the queue, the sequencer and the result valid flag and loads
// the register defaults; wall slots hold nothing defined until written.
// A result waits in its output register while res.ready is low; the back
// end then holds its next result and the queue fills before cmd.ready drops.
module ray_wall_nearest_hit import rwnh_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rwnh_in_if.sink               cmd,
    rwnh_out_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DIST_W-1:0]  min_range_reg;
    logic [COUNT_W-1:0] walls_reg;
    logic [LIMIT_W-1:0] par_limit_reg;
    logic               reg_wr;
    reg_idx_t           reg_idx;
    cfg_t               cfg;
    cmd_t               head;
    logic               head_valid;
    logic               head_pop;
    logic               load_done;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (reg_idx)
            REG_MIN_RANGE: prdata = APB_DATA_W'(min_range_reg);
            REG_WALLS:     prdata = APB_DATA_W'(walls_reg);
            REG_PAR_LIMIT: prdata = APB_DATA_W'(par_limit_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= MIN_RANGE_RST;
            walls_reg     <= WALLS_RST;
            par_limit_reg <= PAR_LIMIT_RST;
        end
        else if (reg_wr)
        begin
            case (reg_idx)
                REG_MIN_RANGE: min_range_reg <= pwdata[DIST_W-1:0];
                REG_WALLS:     walls_reg     <= pwdata[COUNT_W-1:0];
                REG_PAR_LIMIT: par_limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.min_range      = min_range_reg;
        cfg.walls_in_use   = walls_reg;
        cfg.parallel_limit = par_limit_reg;
    end

    rwnh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    rwnh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .cfg        (cfg),
        .res        (res),
        .load_done  (load_done)
    );

`ifndef SYNTHESIS
    a_miss_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.distance == DIST_MISS)
        else $error("miss result without saturated distance");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(load_done))
        else $error("result appeared without a finished cast");

    a_no_pop_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_done |-> !head_pop)
        else $error("request taken while a result is being loaded");
`endif

endmodule
